>>> src/rpq_pkg.sv
package rpq_pkg;

	localparam int LEN_W      = 11;
	localparam int VAL_W      = 31;
	localparam int DEPTH_DEF  = 1024;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_ARRAY_LENGTH = 1'b0;

	typedef struct packed {
		logic [VAL_W-1:0] best;
		logic             found;
	} res_t;

endpackage

>>> src/rpq_ram.sv
module rpq_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/rpq_scan.sv
module rpq_scan #(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rpq_pkg::LEN_W-1:0] array_len,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [rpq_pkg::LEN_W-1:0] position,
	input  logic [rpq_pkg::LEN_W-1:0] range_first,
	input  logic [rpq_pkg::LEN_W-1:0] range_last,
	input  logic [rpq_pkg::VAL_W-1:0] operand_value,
	output logic                      res_valid,
	input  logic                      res_ready,
	output rpq_pkg::res_t             res
);

	import rpq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    last_q;
	logic [VAL_W-1:0] bound_q;
	logic [VAL_W-1:0] best_q;
	logic             hit_q;
	logic             rd_valid_s1;

	logic [CW-1:0]    len_ext;
	logic [CW-1:0]    used_len;
	logic [CW-1:0]    pos_ext;
	logic [CW-1:0]    first_c;
	logic [CW-1:0]    last_ext;
	logic [CW-1:0]    last_c;
	logic             wr_ok;
	logic             empty;
	logic             accept;
	logic             ram_we;
	logic [VAL_W-1:0] rdata;
	logic             take;

	assign len_ext  = CW'(array_len);
	assign used_len = (len_ext > CW'(DEPTH)) ? CW'(DEPTH) : len_ext;
	assign pos_ext  = CW'(position);
	assign wr_ok    = (pos_ext != '0) && (pos_ext <= used_len);
	assign first_c  = (range_first == '0) ? CW'(1) : CW'(range_first);
	assign last_ext = CW'(range_last);
	assign last_c   = (last_ext > used_len) ? used_len : last_ext;
	assign empty    = first_c > last_c;

	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign ram_we    = accept && (command == CMD_WRITE) && wr_ok;
	assign res_valid = state_q == ST_FINISH;
	assign res.best  = best_q;
	assign res.found = hit_q;

	assign take = rd_valid_s1 && (rdata <= bound_q) && (!hit_q || (rdata > best_q));

	rpq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(pos_ext - CW'(1))),
		.wdata(operand_value),
		.raddr(addr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= state_q == ST_SCAN;
			if (take) begin
				best_q <= rdata;
				hit_q  <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (command == CMD_QUERY)) begin
						bound_q <= operand_value;
						best_q  <= '0;
						hit_q   <= 1'b0;
						addr_q  <= AW'(first_c - CW'(1));
						last_q  <= AW'(last_c - CW'(1));
						state_q <= empty ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/range_predecessor_query.sv
// range predecessor query
// keeps an array of 31-bit values at positions 1 to array_length and answers
// range queries for the largest stored value not above a bound
// input channel (in_valid / in_ready): command 0 writes operand_value at
// position, command 1 queries range_first..range_last with bound operand_value
// output channel (out_valid / out_ready): one result per query, none per write
// a query scans range_first..range_last, reading one entry of the value
// memory per cycle, and an empty range skips the scan; the next request is
// accepted once the scan has handed its result on, also while a result still
// waits in the output register; a query result waits for that register to
// drain, so a stalled receiver holds back at most one further query
// reset clears the control state and sets array_length to 1024; the value
// memory is not cleared, and a query must only cover written positions
// array_length is written over the APB port at address 0; the user must write
// it only while idle, and the block itself does not enforce that
module range_predecessor_query #(
	parameter int DEPTH = rpq_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rpq_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rpq_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rpq_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [rpq_pkg::LEN_W-1:0]      position,
	input  logic [rpq_pkg::LEN_W-1:0]      range_first,
	input  logic [rpq_pkg::LEN_W-1:0]      range_last,
	input  logic [rpq_pkg::VAL_W-1:0]      operand_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rpq_pkg::VAL_W-1:0]      best_value,
	output logic                           found
);

	import rpq_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic             out_valid_q;
	res_t             out_q;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1] == REG_ARRAY_LENGTH;
	assign prdata  = reg_sel ? APB_DATA_W'(len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			len_q <= pwdata[LEN_W-1:0];
		end
	end

	assign res_ready = !out_valid_q || out_ready;

	rpq_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.array_len    (len_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.position     (position),
		.range_first  (range_first),
		.range_last   (range_last),
		.operand_value(operand_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_value = out_q.best;
	assign found      = out_q.found;

endmodule

>>> src/rpq_checker.sv
module rpq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      command,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [rpq_pkg::VAL_W-1:0] best_value,
	input logic                      found
);

	import rpq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_value == '0)
		else $error("miss with nonzero value");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
		else $error("request taken during query");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_WRITE && !out_valid |=> !out_valid)
		else $error("write produced a result");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a query in flight");

endmodule

bind range_predecessor_query rpq_checker u_rpq_checker (.*);
